// ----- src/lfr_pkg.sv -----
// Package for the length-prefixed frame receiver.
// Holds the header byte, the parser phase codes and the result beat type.
// No dependencies.
`timescale 1ns / 1ps

package lfr_pkg;

	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] MIN_LEN  = 8'd2;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	typedef struct packed {
		logic       has_result;
		logic [7:0] body_byte;
		logic [7:0] byte_index;
		logic       frame_end;
		logic       checksum_ok;
		logic [7:0] frame_length;
	} result_t;

endpackage

// ----- src/length_checksum_frame_receiver.sv -----
// Top level of the length-prefixed frame receiver with two's complement checksum.
// Input register, lfr_parser, result register. Depends on lfr_pkg and lfr_parser.
//
//   channel  | signals                         | direction
//   ---------+---------------------------------+----------
//   input    | in_valid, in_ready, rx_byte     | in
//   result   | out_valid, out_ready, body_byte,| out
//            | byte_index, frame_end,          |
//            | checksum_ok, frame_length       |
//
// One byte a cycle unless a held result stalls the input. A byte is taken into
// the input register, and its result is then loaded into the result register,
// from which the result beat leaves.
// Header, length and dropped bytes give no result beat.
// Reset clears the parser to hunting and empties both registers.
// A held result stalls only a byte that would itself yield a result.
`timescale 1ns / 1ps

module length_checksum_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] body_byte,
	output logic [7:0] byte_index,
	output logic       frame_end,
	output logic       checksum_ok,
	output logic [7:0] frame_length
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	lfr_pkg::result_t res;
	logic             stall;
	logic             advance;

	lfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	assign stall    = valid_s1 && res.has_result && out_valid && !out_ready;
	assign advance  = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && res.has_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			body_byte    <= res.body_byte;
			byte_index   <= res.byte_index;
			frame_end    <= res.frame_end;
			checksum_ok  <= res.checksum_ok;
			frame_length <= res.frame_length;
		end
	end

	a_end_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> body_byte == 8'd0 && byte_index == 8'd0)
		else $error("frame end beat carries body data");

	a_body_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> !checksum_ok)
		else $error("body beat carries a checksum verdict");

	a_length_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_length >= lfr_pkg::MIN_LEN)
		else $error("result beat with short frame length");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.has_result && out_valid && !out_ready |-> !in_ready && !advance)
		else $error("parser advanced into a held result");

endmodule

// ----- src/lfr_parser.sv -----
// Frame parser: phase, length, running sum and body counters.
// Works out the result of the byte in front of it; state moves on when advance is high.
// Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       byte_in,
	output lfr_pkg::result_t res
);

	logic [1:0] phase_q, phase_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] length_q, length_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] sum_plus;

	assign sum_plus = sum_q + byte_in;

	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		sum_d    = sum_q;
		length_d = length_q;
		pos_d    = pos_q;
		res      = '0;
		res.frame_length = length_q;
		case (phase_q)
			lfr_pkg::PH_LEN: begin
				if (byte_in < lfr_pkg::MIN_LEN) begin
					phase_d = lfr_pkg::PH_HUNT;
				end else begin
					length_d = byte_in;
					sum_d    = byte_in;
					remain_d = byte_in - lfr_pkg::MIN_LEN;
					pos_d    = '0;
					phase_d  = (byte_in != lfr_pkg::MIN_LEN) ? lfr_pkg::PH_BODY
					                                         : lfr_pkg::PH_SUM;
				end
			end
			lfr_pkg::PH_BODY: begin
				res.has_result = 1'b1;
				res.body_byte  = byte_in;
				res.byte_index = pos_q;
				sum_d    = sum_plus;
				pos_d    = pos_q + 8'd1;
				remain_d = remain_q - 8'd1;
				if (remain_q == 8'd1) begin
					phase_d = lfr_pkg::PH_SUM;
				end
			end
			lfr_pkg::PH_SUM: begin
				// sum plus checksum wraps to zero on a good frame
				res.has_result  = 1'b1;
				res.frame_end   = 1'b1;
				res.checksum_ok = (sum_plus == 8'd0);
				phase_d  = lfr_pkg::PH_HUNT;
				remain_d = '0;
			end
			default: begin
				if (byte_in == lfr_pkg::HDR_BYTE) begin
					phase_d = lfr_pkg::PH_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lfr_pkg::PH_HUNT;
			remain_q <= '0;
			sum_q    <= '0;
			length_q <= '0;
			pos_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			sum_q    <= sum_d;
			length_q <= length_d;
			pos_q    <= pos_d;
		end
	end

endmodule
